>>> src/cob_pkg.sv
// ----------------------------------------------------------------------------
// cob_pkg
// Shared types and constants of the cursor overlay alpha blend block.
// ----------------------------------------------------------------------------
package cob_pkg;

   localparam int STORE_DEPTH     = 1024;
   localparam int STORE_AW        = $clog2(STORE_DEPTH);
   localparam int ICON_WIDTH_DEF  = 32;
   localparam int ICON_HEIGHT_DEF = 32;

   localparam int COORD_W  = 12;
   localparam int HOT_W    = 5;
   localparam int SCREEN_W = 13;
   localparam int RGB_W    = 24;
   localparam int WORD_W   = 32;
   localparam int CHAN_W   = 8;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   localparam logic [CHAN_W-1:0]   ALPHA_FULL     = 8'hFF;
   localparam logic [SCREEN_W-1:0] SCREEN_W_RESET = 13'd1024;
   localparam logic [SCREEN_W-1:0] SCREEN_H_RESET = 13'd768;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_PIXEL = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      REG_MOUSE_X   = 3'd0,
      REG_MOUSE_Y   = 3'd1,
      REG_HOTSPOT_X = 3'd2,
      REG_HOTSPOT_Y = 3'd3,
      REG_SCREEN_W  = 3'd4,
      REG_SCREEN_H  = 3'd5
   } reg_index_type;

endpackage

>>> src/cob_if.sv
// ----------------------------------------------------------------------------
// cob_req_if / cob_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface cob_req_if import cob_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [COORD_W-1:0]  pixel_x;
   logic [COORD_W-1:0]  pixel_y;
   logic [RGB_W-1:0]    bg_color;
   logic [STORE_AW-1:0] icon_index;
   logic [WORD_W-1:0]   icon_word;

   modport source (output valid, req_type, pixel_x, pixel_y, bg_color, icon_index,
                   icon_word, input ready);
   modport sink (input valid, req_type, pixel_x, pixel_y, bg_color, icon_index,
                 icon_word, output ready);
endinterface

interface cob_rsp_if import cob_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RGB_W-1:0] out_color;
   logic             cursor_touched;

   modport source (output valid, out_color, cursor_touched, input ready);
   modport sink (input valid, out_color, cursor_touched, output ready);
endinterface

>>> src/cursor_overlay_alpha_blend_top.sv
// ----------------------------------------------------------------------------
// cursor_overlay_alpha_blend_top
// Hardware cursor overlay: icon store in a synchronous memory, clip and icon
// hit test, ARGB8888 alpha blend over the background pixel.
// ----------------------------------------------------------------------------
// an accepted pixel transfer passes the stage 1, stage 2 and output registers to its result transfer
// throughput: one item per cycle, load or pixel, unless the result channel stalls; each takes one store access
// load transfers write the store at acceptance and give no result
// reset: synchronous, clears pipeline valids and the position/hotspot registers, sets screen size to 1024x768;
// the icon store is not cleared and must be loaded before use
// ----------------------------------------------------------------------------
module cursor_overlay_alpha_blend_top import cob_pkg::*; #(
   parameter int ICON_WIDTH  = ICON_WIDTH_DEF,
   parameter int ICON_HEIGHT = ICON_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   cob_req_if.sink           req_ch,
   cob_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam logic signed [COORD_W+1:0] IconWs = (COORD_W+2)'(ICON_WIDTH);
   localparam logic signed [COORD_W+1:0] IconHs = (COORD_W+2)'(ICON_HEIGHT);
   localparam logic [COORD_W:0]          IconWu = (COORD_W+1)'(ICON_WIDTH);

   // configuration registers
   logic [COORD_W-1:0]  mouse_x_ff, mouse_y_ff;
   logic [HOT_W-1:0]    hotspot_x_ff, hotspot_y_ff;
   logic [SCREEN_W-1:0] screen_w_ff, screen_h_ff;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mouse_x_ff   <= '0;
         mouse_y_ff   <= '0;
         hotspot_x_ff <= '0;
         hotspot_y_ff <= '0;
         screen_w_ff  <= SCREEN_W_RESET;
         screen_h_ff  <= SCREEN_H_RESET;
      end else if (csr_write) begin
         case (paddr[CSR_AW-1:2])
            REG_MOUSE_X:   mouse_x_ff   <= pwdata[COORD_W-1:0];
            REG_MOUSE_Y:   mouse_y_ff   <= pwdata[COORD_W-1:0];
            REG_HOTSPOT_X: hotspot_x_ff <= pwdata[HOT_W-1:0];
            REG_HOTSPOT_Y: hotspot_y_ff <= pwdata[HOT_W-1:0];
            REG_SCREEN_W:  screen_w_ff  <= pwdata[SCREEN_W-1:0];
            REG_SCREEN_H:  screen_h_ff  <= pwdata[SCREEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_AW-1:2])
         REG_MOUSE_X:   prdata = CSR_DW'(mouse_x_ff);
         REG_MOUSE_Y:   prdata = CSR_DW'(mouse_y_ff);
         REG_HOTSPOT_X: prdata = CSR_DW'(hotspot_x_ff);
         REG_HOTSPOT_Y: prdata = CSR_DW'(hotspot_y_ff);
         REG_SCREEN_W:  prdata = CSR_DW'(screen_w_ff);
         REG_SCREEN_H:  prdata = CSR_DW'(screen_h_ff);
         default:       prdata = '0;
      endcase
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_rdy, s2_en, s1_en, accept;

   assign out_rdy      = !rsp_valid_ff || rsp_ch.ready;
   assign s2_en        = !s2_valid_ff || out_rdy;
   assign s1_en        = !s1_valid_ff || s2_en;
   assign req_ch.ready = s1_en;
   assign accept       = req_ch.valid && s1_en;

   // stage 0: clip and icon hit test, store address
   logic signed [COORD_W+1:0] col, row;
   logic                      on_screen, in_icon;
   logic [STORE_AW-1:0]       rd_addr;

   always_comb begin
      col = $signed({2'b00, req_ch.pixel_x}) - $signed({2'b00, mouse_x_ff})
            + $signed((COORD_W+2)'(hotspot_x_ff));
      row = $signed({2'b00, req_ch.pixel_y}) - $signed({2'b00, mouse_y_ff})
            + $signed((COORD_W+2)'(hotspot_y_ff));
      on_screen = ({1'b0, req_ch.pixel_x} < screen_w_ff)
                  && ({1'b0, req_ch.pixel_y} < screen_h_ff);
      in_icon = (col >= 0) && (col < IconWs) && (row >= 0) && (row < IconHs);
      rd_addr = STORE_AW'(row[COORD_W:0] * IconWu + col[COORD_W:0]);
   end

   // icon store
   logic [WORD_W-1:0] icon_store [STORE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (accept && req_ch.req_type == REQ_LOAD) begin
         icon_store[req_ch.icon_index] <= req_ch.icon_word;
      end
      if (s1_en) begin
         rd_data_ff <= icon_store[rd_addr];
      end
   end

   // stage 1: texel available, channel products
   logic             s1_hit_ff;
   logic [RGB_W-1:0] s1_bg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= accept && req_ch.req_type == REQ_PIXEL;
      end
      if (s1_en) begin
         s1_hit_ff <= on_screen && in_icon;
         s1_bg_ff  <= req_ch.bg_color;
      end
   end

   logic [CHAN_W-1:0]        alpha, alpha_inv;
   logic [2:0][2*CHAN_W-1:0] sum_in;

   always_comb begin
      alpha     = rd_data_ff[WORD_W-1 -: CHAN_W];
      alpha_inv = ALPHA_FULL - alpha;
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = (2*CHAN_W)'(rd_data_ff[c*CHAN_W +: CHAN_W] * alpha)
                     + (2*CHAN_W)'(s1_bg_ff[c*CHAN_W +: CHAN_W] * alpha_inv);
      end
   end

   // stage 2: registered sums, divide by 255 and select
   logic                     s2_touch_ff, s2_full_ff;
   logic [RGB_W-1:0]         s2_bg_ff, s2_rgb_ff;
   logic [2:0][2*CHAN_W-1:0] s2_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_en) begin
         s2_touch_ff <= s1_hit_ff && (alpha != '0);
         s2_full_ff  <= (alpha == ALPHA_FULL);
         s2_bg_ff    <= s1_bg_ff;
         s2_rgb_ff   <= rd_data_ff[RGB_W-1:0];
         s2_sum_ff   <= sum_in;
      end
   end

   logic [2*CHAN_W:0] quot_full [3];
   logic [RGB_W-1:0]  blend_rgb, color_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         // exact x/255 for x below 65535
         quot_full[c] = {1'b0, s2_sum_ff[c]} + (2*CHAN_W+1)'(s2_sum_ff[c][2*CHAN_W-1:CHAN_W])
                        + (2*CHAN_W+1)'(1);
         blend_rgb[c*CHAN_W +: CHAN_W] = quot_full[c][2*CHAN_W-1:CHAN_W];
      end
      if (!s2_touch_ff) begin
         color_in = s2_bg_ff;
      end else if (s2_full_ff) begin
         color_in = s2_rgb_ff;
      end else begin
         color_in = blend_rgb;
      end
   end

   // output register
   logic [RGB_W-1:0] rsp_color_ff;
   logic             rsp_touched_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (out_rdy) begin
         rsp_color_ff   <= color_in;
         rsp_touched_ff <= s2_touch_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_color      = rsp_color_ff;
   assign rsp_ch.cursor_touched = rsp_touched_ff;

endmodule

>>> src/cob_checker.sv
// ----------------------------------------------------------------------------
// cob_checker
// Port-level checks of the cursor overlay block, bound to the top level.
// ----------------------------------------------------------------------------
module cob_checker import cob_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [RGB_W-1:0]  out_color,
   input logic              cursor_touched,
   input logic              psel,
   input logic              penable,
   input logic              pwrite,
   input logic [CSR_AW-1:0] paddr,
   input logic [CSR_DW-1:0] pwdata,
   input logic [CSR_DW-1:0] prdata,
   input logic              pready
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // empty output register never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_color)
                                  && $stable(cursor_touched))
      else $error("stalled result changed");

   // register readback after a write
   a_mouse_x_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && paddr[CSR_AW-1:2] == REG_MOUSE_X)
      ##1 (psel && !pwrite && paddr[CSR_AW-1:2] == REG_MOUSE_X)
      |-> prdata == CSR_DW'($past(pwdata[COORD_W-1:0])))
      else $error("mouse_x readback mismatch");

endmodule

bind cursor_overlay_alpha_blend_top cob_checker u_cob_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .out_color      (rsp_ch.out_color),
   .cursor_touched (rsp_ch.cursor_touched),
   .psel           (psel),
   .penable        (penable),
   .pwrite         (pwrite),
   .paddr          (paddr),
   .pwdata         (pwdata),
   .prdata         (prdata),
   .pready         (pready)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cursor overlay block. Icon words and pixels go
// in on the request channel and blended pixels come back on the result
// channel. A scoreboard keeps its own icon store and cursor registers and
// predicts each pixel: clipping, icon hit test, transparent, opaque and
// partial alpha. Both channels stall at random. Cursor registers are
// rewritten over APB between phases, from reset values to the extremes.
// ----------------------------------------------------------------------------
import cob_pkg::*;

typedef struct {
   req_kind_type        kind;
   logic [COORD_W-1:0]  px;
   logic [COORD_W-1:0]  py;
   logic [RGB_W-1:0]    bg;
   logic [STORE_AW-1:0] idx;
   logic [WORD_W-1:0]   word;
} overlay_req_type;

typedef struct {
   logic [RGB_W-1:0] color;
   logic             touched;
} pixel_out_type;

class overlay_checker;
   logic [COORD_W-1:0]  mouse_x = '0;
   logic [COORD_W-1:0]  mouse_y = '0;
   logic [HOT_W-1:0]    hot_x   = '0;
   logic [HOT_W-1:0]    hot_y   = '0;
   logic [SCREEN_W-1:0] scr_w   = SCREEN_W_RESET;
   logic [SCREEN_W-1:0] scr_h   = SCREEN_H_RESET;
   logic [WORD_W-1:0]   icon_words [STORE_DEPTH];
   bit                  loaded [STORE_DEPTH];
   pixel_out_type       expected_pixels [$];
   int                  mismatches  = 0;
   int                  checked     = 0;
   int                  touched_cnt = 0;

   function void set_reg(reg_index_type r, logic [CSR_DW-1:0] v);
      case (r)
         REG_MOUSE_X:   mouse_x = v[COORD_W-1:0];
         REG_MOUSE_Y:   mouse_y = v[COORD_W-1:0];
         REG_HOTSPOT_X: hot_x   = v[HOT_W-1:0];
         REG_HOTSPOT_Y: hot_y   = v[HOT_W-1:0];
         REG_SCREEN_W:  scr_w   = v[SCREEN_W-1:0];
         REG_SCREEN_H:  scr_h   = v[SCREEN_W-1:0];
         default: ;
      endcase
   endfunction

   function logic [CSR_DW-1:0] reg_value(reg_index_type r);
      case (r)
         REG_MOUSE_X:   return CSR_DW'(mouse_x);
         REG_MOUSE_Y:   return CSR_DW'(mouse_y);
         REG_HOTSPOT_X: return CSR_DW'(hot_x);
         REG_HOTSPOT_Y: return CSR_DW'(hot_y);
         REG_SCREEN_W:  return CSR_DW'(scr_w);
         REG_SCREEN_H:  return CSR_DW'(scr_h);
         default:       return '0;
      endcase
   endfunction

   // on screen and inside the icon placed at pointer minus hotspot
   function bit icon_hit(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                         output logic [STORE_AW-1:0] addr);
      int col, row;
      addr = '0;
      if (px >= scr_w || py >= scr_h) return 0;
      col = int'(px) - int'(mouse_x) + int'(hot_x);
      row = int'(py) - int'(mouse_y) + int'(hot_y);
      if (col < 0 || col >= ICON_WIDTH_DEF || row < 0 || row >= ICON_HEIGHT_DEF) return 0;
      addr = STORE_AW'(row * ICON_WIDTH_DEF + col);
      return 1;
   endfunction

   function pixel_out_type overlay_pixel(overlay_req_type r);
      pixel_out_type       o;
      logic [STORE_AW-1:0] addr;
      logic [WORD_W-1:0]   t;
      int unsigned         a;
      o.color   = r.bg;
      o.touched = 1'b0;
      if (!icon_hit(r.px, r.py, addr)) return o;
      t = icon_words[addr];
      a = t[31:24];
      if (a == 0) return o;
      o.touched = 1'b1;
      if (t[31:24] == ALPHA_FULL) begin
         o.color = t[RGB_W-1:0];
      end else begin
         for (int c = 0; c < 3; c++)
            o.color[c*CHAN_W +: CHAN_W] =
               CHAN_W'((t[c*CHAN_W +: CHAN_W] * a + r.bg[c*CHAN_W +: CHAN_W] * (255 - a)) / 255);
      end
      return o;
   endfunction

   function void note_request(overlay_req_type r);
      if (r.kind == REQ_LOAD) begin
         icon_words[r.idx] = r.word;
         loaded[r.idx]     = 1'b1;
      end else begin
         expected_pixels.push_back(overlay_pixel(r));
      end
   endfunction

   function void check_pixel(logic [RGB_W-1:0] color, logic touched);
      pixel_out_type e;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result transfer, expected none, actual color %06h touched %b",
                  $time, color, touched);
         return;
      end
      e = expected_pixels.pop_front();
      checked++;
      if (touched === 1'b1) touched_cnt++;
      if (color !== e.color) begin
         mismatches++;
         $display("%0t: out_color mismatch, expected %06h actual %06h", $time, e.color, color);
      end
      if (touched !== e.touched) begin
         mismatches++;
         $display("%0t: cursor_touched mismatch, expected %b actual %b",
                  $time, e.touched, touched);
      end
   endfunction

   function int pending();
      return expected_pixels.size();
   endfunction
endclass

module tb_top;
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;
   bit                calm = 1'b0;
   int                n_loads = 0;
   int                n_pixels = 0;
   int                n_settings = 0;
   overlay_checker    ck;

   cob_req_if req_ch ();
   cob_rsp_if rsp_ch ();

   cursor_overlay_alpha_blend_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("tb_top: timeout with %0d results outstanding", ck.pending());
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [WORD_W-1:0] random_texel();
      logic [WORD_W-1:0] w;
      int                r;
      w = $urandom;
      r = $urandom_range(0, 99);
      if (r < 20)      w[31:24] = 8'h00;
      else if (r < 40) w[31:24] = ALPHA_FULL;
      else if (r < 45) w[31:24] = 8'h01;
      else if (r < 50) w[31:24] = 8'hFE;
      return w;
   endfunction

   function automatic overlay_req_type load_req(logic [STORE_AW-1:0] idx, logic [WORD_W-1:0] w);
      overlay_req_type r;
      r.kind = REQ_LOAD;
      r.idx  = idx;
      r.word = w;
      r.px   = COORD_W'($urandom);
      r.py   = COORD_W'($urandom);
      r.bg   = RGB_W'($urandom);
      return r;
   endfunction

   function automatic overlay_req_type pixel_req(logic [COORD_W-1:0] px,
                                                 logic [COORD_W-1:0] py,
                                                 logic [RGB_W-1:0] bg);
      overlay_req_type r;
      r.kind = REQ_PIXEL;
      r.px   = px;
      r.py   = py;
      r.bg   = bg;
      r.idx  = STORE_AW'($urandom);
      r.word = $urandom;
      return r;
   endfunction

   function automatic overlay_req_type random_req();
      overlay_req_type r;
      int              m;
      if ($urandom_range(0, 99) < 20) return load_req(STORE_AW'($urandom), random_texel());
      r = pixel_req(COORD_W'($urandom), COORD_W'($urandom), RGB_W'($urandom));
      m = $urandom_range(0, 99);
      if (m < 65) begin
         // around the icon, a few pixels beyond each side
         r.px = COORD_W'(int'(ck.mouse_x) - int'(ck.hot_x) + int'($urandom_range(0, 39)) - 4);
         r.py = COORD_W'(int'(ck.mouse_y) - int'(ck.hot_y) + int'($urandom_range(0, 39)) - 4);
      end else if (m < 80) begin
         // at the clipping edges
         r.px = COORD_W'(int'(ck.scr_w) + int'($urandom_range(0, 4)) - 3);
         r.py = COORD_W'(int'(ck.scr_h) + int'($urandom_range(0, 4)) - 3);
      end
      return r;
   endfunction

   task automatic send_req(overlay_req_type r);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.req_type   = r.kind;
      req_ch.pixel_x    = r.px;
      req_ch.pixel_y    = r.py;
      req_ch.bg_color   = r.bg;
      req_ch.icon_index = r.idx;
      req_ch.icon_word  = r.word;
      req_ch.valid      = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      ck.note_request(r);
      if (r.kind == REQ_LOAD) n_loads++;
      else n_pixels++;
      @(negedge clock);
   endtask

   // never let a pixel read an icon entry that has not been loaded
   task automatic send_guarded(overlay_req_type r);
      logic [STORE_AW-1:0] addr;
      if (r.kind == REQ_PIXEL && ck.icon_hit(r.px, r.py, addr) && !ck.loaded[addr])
         send_req(load_req(addr, random_texel()));
      send_req(r);
   endtask

   task automatic settle();
      req_ch.valid = 1'b0;
      while (ck.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type r, logic [CSR_DW-1:0] v);
      logic [CSR_DW-1:0] got;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_AW'(4 * int'(r));
      pwdata  = v;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      ck.set_reg(r, v);
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      got = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (got !== ck.reg_value(r)) begin
         ck.mismatches++;
         $display("%0t: readback of %s, expected %0h actual %0h",
                  $time, r.name(), ck.reg_value(r), got);
      end
   endtask

   task automatic set_cursor(int mx, int my, int hx, int hy, int sw, int sh);
      settle();
      write_reg(REG_MOUSE_X, mx);
      write_reg(REG_MOUSE_Y, my);
      write_reg(REG_HOTSPOT_X, hx);
      write_reg(REG_HOTSPOT_Y, hy);
      write_reg(REG_SCREEN_W, sw);
      write_reg(REG_SCREEN_H, sh);
      n_settings++;
   endtask

   // n counts every transfer, icon loads for unloaded entries included
   task automatic run_random(int n);
      int start;
      start = n_loads + n_pixels;
      for (int i = 0; n_loads + n_pixels - start < n; i++) begin
         if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
         send_guarded(random_req());
      end
      calm = 1'b0;
   endtask

   // reset register values: icon top-left on the screen origin
   task automatic run_directed();
      send_guarded(load_req(0, 32'h00ABCDEF));
      send_guarded(load_req(1, 32'hFF123456));
      send_guarded(load_req(2, 32'h80FF00FF));
      send_guarded(load_req(3, 32'h01FFFFFF));
      send_guarded(load_req(4, 32'h80808080));
      send_guarded(load_req(32, 32'hFEFFFFFF));
      send_guarded(load_req(33, 32'h7F000000));
      send_guarded(load_req(1023, 32'hFFFFFFFF));
      send_guarded(pixel_req(0, 0, 24'hFFFFFF));
      send_guarded(pixel_req(1, 0, 24'h000000));
      send_guarded(pixel_req(2, 0, 24'h00FF00));
      send_guarded(pixel_req(3, 0, 24'h000000));
      send_guarded(pixel_req(4, 0, 24'h808080));
      send_guarded(pixel_req(0, 1, 24'h000000));
      send_guarded(pixel_req(1, 1, 24'hFFFFFF));
      send_guarded(pixel_req(31, 31, 24'h123456));
      send_guarded(pixel_req(32, 0, 24'hABCDEF));
      send_guarded(pixel_req(0, 32, 24'hABCDEF));
      send_guarded(pixel_req(1024, 0, 24'hFFFFFF));
      send_guarded(pixel_req(0, 768, 24'hFFFFFF));
      send_guarded(pixel_req(4095, 4095, 24'hFFFFFF));
      send_guarded(pixel_req(1023, 767, 24'h000000));
   endtask

   initial begin : rsp_stall
      int run;
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         run = $urandom_range(1, 30);
         rsp_ch.ready = 1'b1;
         repeat (run) @(negedge clock);
         gap = calm ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         ck.check_pixel(rsp_ch.out_color, rsp_ch.cursor_touched);
   end

   initial begin : stimulus
      int sw;
      int sh;
      ck = new;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = REQ_LOAD;
      req_ch.pixel_x    = '0;
      req_ch.pixel_y    = '0;
      req_ch.bg_color   = '0;
      req_ch.icon_index = '0;
      req_ch.icon_word  = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      run_directed();
      run_random(100);
      set_cursor(4095, 4095, 31, 31, 4096, 4096);
      run_random(280);
      set_cursor(0, 0, 0, 0, 1, 1);
      run_random(100);
      set_cursor(0, 0, 31, 31, 4096, 4096);
      run_random(100);
      set_cursor(2000, 1000, 16, 16, 0, 0);
      run_random(100);
      set_cursor(4095, 0, 0, 31, 4096, 4096);
      run_random(100);
      repeat (4) begin
         sw = $urandom_range(0, 1) ? 4096 : $urandom_range(1, 4096);
         sh = $urandom_range(0, 1) ? 4096 : $urandom_range(1, 4096);
         set_cursor($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 31), $urandom_range(0, 31), sw, sh);
         run_random(270);
      end
      settle();

      $display("tb_top: %0d icon loads and %0d pixels sent under %0d cursor settings",
               n_loads, n_pixels, n_settings);
      $display("tb_top: %0d pixels checked, %0d of them covered by the cursor",
               ck.checked, ck.touched_cnt);
      if (ck.mismatches == 0 && ck.pending() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule

>>> cursor_overlay_alpha_blend_top.f
src/cob_pkg.sv
src/cob_if.sv
src/cursor_overlay_alpha_blend_top.sv
src/cob_checker.sv
verif/tb_top.sv
